### hdl/rdc_pkg.sv
// Shared constants and helpers for the retrigger/decay cell array.
// No dependencies; imported by the core and the checker.
package rdc_pkg;

    localparam int CELLS_DEF = 1024;
    localparam int CELL_W    = 64;
    localparam int ACTIVE_W  = 11;
    localparam int PREC_W    = 2;
    localparam int SIGNAL_W  = 8;
    localparam int LEVEL_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CELLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_VALUE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP   = 2'd3;

    // Cell width codes
    localparam logic [PREC_W-1:0] PREC_8  = 2'd0;
    localparam logic [PREC_W-1:0] PREC_16 = 2'd1;
    localparam logic [PREC_W-1:0] PREC_32 = 2'd2;
    localparam logic [PREC_W-1:0] PREC_64 = 2'd3;

    // Register reset values
    localparam logic [ACTIVE_W-1:0] ACTIVE_CELLS_RST = 11'd1024;
    localparam logic [PREC_W-1:0]   PRECISION_RST    = PREC_8;
    localparam logic [CELL_W-1:0]   HOLD_VALUE_RST   = 64'd255;
    localparam logic [CELL_W-1:0]   DECAY_STEP_RST   = 64'd1;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 8'hFF;

    // Largest value a cell holds at the given width code
    function automatic logic [CELL_W-1:0] width_mask(input logic [PREC_W-1:0] prec);
        logic [CELL_W-1:0] m;
        case (prec)
            PREC_8:  m = 64'h0000_0000_0000_00FF;
            PREC_16: m = 64'h0000_0000_0000_FFFF;
            PREC_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

### hdl/retrigger_decay_cell_array_core.sv
// Path: an accepted input is registered in stage 1, then its result in the output
// register, where it is held while out_ready is low.
// Throughput: one item per cycle while the output is not stalled, set by the
// read-modify-write loop on the cell RAM (read in the accept cycle, updated and
// written back when stage 1 advances, forwarded on reuse).
// Reset: asynchronous, active low; registers return to defaults, then a clearing
// pass zeroes the cell RAM while in_ready stays low. Depends on rdc_pkg and rdc_ram.
module retrigger_decay_cell_array_core
    import rdc_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CELL_W-1:0]    cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SIGNAL_W-1:0]  signal,
    // result channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 active,
    output logic [LEVEL_W-1:0]   level,
    output logic                 last_cell
);

    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CMP_W  = (ADDR_W + 1 > ACTIVE_W) ? ADDR_W + 1 : ACTIVE_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

    // configuration registers
    logic [ACTIVE_W-1:0] active_cells_reg;
    logic [PREC_W-1:0]   precision_reg;
    logic [CELL_W-1:0]   hold_value_reg;
    logic [CELL_W-1:0]   decay_step_reg;

    // control state
    logic                clearing_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [ADDR_W-1:0]   position_reg;
    logic [ADDR_W-1:0]   position_next;
    logic                s1_valid_reg;
    logic                out_valid_reg;
    logic                fwd_valid_reg;

    // payload registers
    logic [ADDR_W-1:0]   s1_idx_reg;
    logic                s1_trig_reg;
    logic                s1_last_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    logic [CELL_W-1:0]   fwd_data_reg;
    logic                active_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                last_cell_reg;

    logic [CMP_W-1:0]    active_ext;
    logic [ADDR_W-1:0]   last_idx;
    logic [CELL_W-1:0]   mask;
    logic [CELL_W-1:0]   hold_clamp;
    logic                pos_last;
    logic [ADDR_W-1:0]   rd_idx;
    logic                in_acc;
    logic                s1_adv;
    logic [CELL_W-1:0]   ram_rdata;
    logic [CELL_W-1:0]   cell_old;
    logic [CELL_W-1:0]   cell_cur;
    logic [CELL_W-1:0]   cell_new;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;

    assign cfg_ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_cells_reg <= ACTIVE_CELLS_RST;
            precision_reg    <= PRECISION_RST;
            hold_value_reg   <= HOLD_VALUE_RST;
            decay_step_reg   <= DECAY_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACTIVE_CELLS: active_cells_reg <= cfg_data[ACTIVE_W-1:0];
                CFG_PRECISION:    precision_reg    <= cfg_data[PREC_W-1:0];
                CFG_HOLD_VALUE:   hold_value_reg   <= cfg_data;
                CFG_DECAY_STEP:   decay_step_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Derive the last cell of a pass, treating zero as one and capping at CELLS
    assign active_ext = CMP_W'(active_cells_reg);

    always_comb
    begin
        if (active_ext == '0)
        begin
            last_idx = '0;
        end
        else if (active_ext > CMP_W'(CELLS))
        begin
            last_idx = LAST_ADDR;
        end
        else
        begin
            last_idx = ADDR_W'(active_ext - CMP_W'(1));
        end
    end

    // Clamp the hold value to the cell width
    assign mask       = width_mask(precision_reg);
    assign hold_clamp = (hold_value_reg > mask) ? mask : hold_value_reg;

    // Handshake: stage 1 moves on when the output register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign in_acc   = in_valid && in_ready;

    // Stage 0: pick the cell and advance the position counter
    assign pos_last      = (position_reg >= last_idx);
    assign rd_idx        = pos_last ? last_idx : position_reg;
    assign position_next = pos_last ? '0 : position_reg + ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                position_reg <= position_next;
            end
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_idx_reg  <= rd_idx;
            s1_trig_reg <= (signal != '0);
            s1_last_reg <= pos_last;
        end
    end

    // Stage 1: forward the last write on an address match, then update the cell
    assign cell_old = (fwd_valid_reg && (fwd_addr_reg == s1_idx_reg)) ? fwd_data_reg
                                                                       : ram_rdata;
    assign cell_cur = cell_old & mask;

    always_comb
    begin
        if (s1_trig_reg)
        begin
            cell_new = hold_clamp;
        end
        else if (cell_cur >= decay_step_reg)
        begin
            cell_new = cell_cur - decay_step_reg;
        end
        else
        begin
            cell_new = '0;
        end
    end

    // Hold the most recent write for the forwarding path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            fwd_addr_reg <= s1_idx_reg;
            fwd_data_reg <= cell_new;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            active_reg    <= (cell_new != '0);
            level_reg     <= (cell_new > CELL_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                             : cell_new[LEVEL_W-1:0];
            last_cell_reg <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign active    = active_reg;
    assign level     = level_reg;
    assign last_cell = last_cell_reg;

    // Sweep the RAM to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Write port: clearing pass first, then cell updates
    assign ram_we    = clearing_reg || s1_adv;
    assign ram_waddr = clearing_reg ? clr_addr_reg : s1_idx_reg;
    assign ram_wdata = clearing_reg ? '0 : cell_new;

    rdc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

endmodule

### hdl/rdc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the cell store; no package dependency.
module rdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; a same-address read returns the old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/rdc_checker.sv
// Port-level checks for the retrigger/decay cell array, bound to the top level.
// Depends on rdc_pkg.
module rdc_checker
    import rdc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 active,
    input logic [LEVEL_W-1:0]   level,
    input logic                 last_cell
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_xact;
    logic       out_xact;

    assign in_xact  = in_valid && in_ready;
    assign out_xact = out_valid && out_ready;

    // Count transactions in flight
    always_comb
    begin
        pend_next = pend_reg;
        if (in_xact && !out_xact)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_xact && out_xact)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A result never appears without an accepted input behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result without a pending input transaction");

    // At most two items ever in flight
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more items in flight than pipeline stages");

    // Active flag agrees with the clamped level
    a_active_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (active == (level != '0)))
        else $error("active flag disagrees with level");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(active) && $stable(level) && $stable(last_cell)))
        else $error("stalled result changed");

endmodule

bind retrigger_decay_cell_array_core rdc_checker u_rdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .active    (active),
    .level     (level),
    .last_cell (last_cell)
);
